>>> hdl/ogff_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flood fill unit package
// Shared widths, command and register codes, sequencer states and the
// control words passed between the flood fill unit's modules.
// ----------------------------------------------------------------------------
package ogff_pkg;

   localparam int MAX_DIM_DEFAULT = 64;
   localparam int DEFAULT_IDX_W   = $clog2(MAX_DIM_DEFAULT * MAX_DIM_DEFAULT);
   localparam int DEFAULT_DIM_W   = $clog2(MAX_DIM_DEFAULT + 1);
   localparam int DEFAULT_COORD_W = $clog2(MAX_DIM_DEFAULT);

   localparam int CMD_W        = 2;
   localparam int INDEX_W      = 12;
   localparam int VALUE_W      = 8;
   localparam int COORD_PORT_W = 6;
   localparam int DIM_REG_W    = 7;
   localparam int CSR_INDEX_W  = 1;
   localparam int MAX_HITS     = 4;
   localparam int HIT_PTR_W    = 2;
   localparam int HIT_CNT_W    = 3;

   localparam logic [DIM_REG_W-1:0] DIM_RESET = 7'd64;

   localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_START = 2'd1;
   localparam logic [CMD_W-1:0] CMD_STEP  = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] REG_GRID_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_GRID_HEIGHT = 1'b1;

   localparam logic [1:0] DIR_NORTH = 2'd0;
   localparam logic [1:0] DIR_EAST  = 2'd1;
   localparam logic [1:0] DIR_SOUTH = 2'd2;
   localparam logic [1:0] DIR_WEST  = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_SEED,
      ST_POP,
      ST_FETCH,
      ST_DIVIDE,
      ST_ADDR,
      ST_CHECK,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      logic load_we;
      logic read_en;
      logic vis_we;
      logic vis_bit;
   } cell_ctrl_type;

   typedef struct packed {
      logic flush;
      logic push;
      logic pop;
   } queue_ctrl_type;

endpackage

>>> hdl/ogff_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flood fill index divider
// Restoring divider that splits a cell index into row and column, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module ogff_divider #(
   parameter int DIVIDEND_W = ogff_pkg::DEFAULT_IDX_W,
   parameter int DIVISOR_W  = ogff_pkg::DEFAULT_DIM_W
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  busy,
   output logic [DIVIDEND_W-1:0] quotient,
   output logic [DIVISOR_W-1:0]  remainder
);
   import ogff_pkg::*;

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic [DIVIDEND_W-1:0] quot_ff, quot_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  divisor_ff, divisor_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  busy_ff, busy_in;
   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    diff;
   logic                  fits;

   always_comb begin
      trial      = {rem_ff, quot_ff[DIVIDEND_W-1]};
      diff       = trial - {1'b0, divisor_ff};
      fits       = trial >= {1'b0, divisor_ff};
      quot_in    = quot_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      count_in   = count_ff;
      busy_in    = busy_ff;
      if (busy_ff) begin
         quot_in  = {quot_ff[DIVIDEND_W-2:0], fits};
         rem_in   = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         count_in = count_ff - CNT_W'(1);
         if (count_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end else if (start) begin
         quot_in    = dividend;
         rem_in     = '0;
         divisor_in = divisor;
         count_in   = CNT_W'(DIVIDEND_W);
         busy_in    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff    <= quot_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign busy      = busy_ff;
   assign quotient  = quot_ff;
   assign remainder = rem_ff;

endmodule

>>> hdl/ogff_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flood fill cell queue
// First-in first-out store of queued cells with head and tail pointers and
// a registered read port.
// ----------------------------------------------------------------------------
module ogff_queue #(
   parameter int DEPTH   = ogff_pkg::MAX_DIM_DEFAULT * ogff_pkg::MAX_DIM_DEFAULT,
   parameter int ADDR_W  = ogff_pkg::DEFAULT_IDX_W,
   parameter int ENTRY_W = ogff_pkg::DEFAULT_IDX_W + 2 * ogff_pkg::DEFAULT_COORD_W
                           + ogff_pkg::DEFAULT_DIM_W
) (
   input  logic                     clock,
   input  logic                     reset,
   input  ogff_pkg::queue_ctrl_type ctrl,
   input  logic [ENTRY_W-1:0]       push_data,
   output logic [ENTRY_W-1:0]       pop_data,
   output logic                     empty
);
   import ogff_pkg::*;

   logic [ENTRY_W-1:0] mem [DEPTH];
   logic [ENTRY_W-1:0] pop_data_ff;
   logic [ADDR_W:0]    head_ff, head_in;
   logic [ADDR_W:0]    tail_ff, tail_in;
   logic               do_push;
   logic               do_pop;

   always_comb begin
      do_push = ctrl.push && (tail_ff != (ADDR_W + 1)'(DEPTH));
      do_pop  = ctrl.pop && (head_ff != tail_ff);
      head_in = head_ff;
      tail_in = tail_ff;
      if (ctrl.flush) begin
         head_in = '0;
         tail_in = '0;
      end else begin
         if (do_push) begin
            tail_in = tail_ff + (ADDR_W + 1)'(1);
         end
         if (do_pop) begin
            head_in = head_ff + (ADDR_W + 1)'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push && !ctrl.flush) begin
         mem[tail_ff[ADDR_W-1:0]] <= push_data;
      end
      if (do_pop) begin
         pop_data_ff <= mem[head_ff[ADDR_W-1:0]];
      end
   end

   assign pop_data = pop_data_ff;
   assign empty    = (head_ff == tail_ff);

endmodule

>>> hdl/ogff_cell_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flood fill cell store
// Free map and visited map, one bit per cell, with registered reads at a
// shared address.
// ----------------------------------------------------------------------------
module ogff_cell_store #(
   parameter int DEPTH  = ogff_pkg::MAX_DIM_DEFAULT * ogff_pkg::MAX_DIM_DEFAULT,
   parameter int ADDR_W = ogff_pkg::DEFAULT_IDX_W
) (
   input  logic                    clock,
   input  ogff_pkg::cell_ctrl_type ctrl,
   input  logic [ADDR_W-1:0]       load_addr,
   input  logic                    load_free,
   input  logic [ADDR_W-1:0]       vis_addr,
   input  logic [ADDR_W-1:0]       rd_addr,
   output logic                    free_bit,
   output logic                    visited_bit
);
   import ogff_pkg::*;

   logic free_mem [DEPTH];
   logic visited_mem [DEPTH];
   logic free_ff;
   logic visited_ff;

   always_ff @(posedge clock) begin
      if (ctrl.load_we) begin
         free_mem[load_addr] <= load_free;
      end
      if (ctrl.read_en) begin
         free_ff <= free_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.vis_we) begin
         visited_mem[vis_addr] <= ctrl.vis_bit;
      end
      if (ctrl.read_en) begin
         visited_ff <= visited_mem[rd_addr];
      end
   end

   assign free_bit    = free_ff;
   assign visited_bit = visited_ff;

endmodule

>>> hdl/occupancy_grid_flood_fill_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Occupancy grid flood fill unit
// Breadth-first 4-connected flood fill over an occupancy grid held in
// on-chip memories: load cells, seed a fill, then advance one cell per step.
//
//   channel  direction  handshake             word
//   req      in         req_valid/req_ready   cmd, cell index/value, seed
//   rsp      out        rsp_valid/rsp_ready   found cell, flags
//   csr      in         csr_valid/csr_ready   register index, write data
//
// A start clears the visited map one entry per cycle, then queues the seed
// if it lies inside the grid. A step pops and fetches a cell, then takes
// each neighbour through an address state and a check state on the single
// read port of the cell store, then drains its result words; on an empty
// queue it goes straight to the drain. A cell queued under another grid
// width first passes through the divider to recover its row and column.
// Reset clears the sequencer, queue pointers and registers; the maps keep
// their contents. A stalled rsp holds the step in its drain.
// ----------------------------------------------------------------------------
module occupancy_grid_flood_fill_unit #(
   parameter int MAX_DIM = ogff_pkg::MAX_DIM_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic [ogff_pkg::CMD_W-1:0]              req_cmd,
   input  logic [ogff_pkg::INDEX_W-1:0]            req_cell_index,
   input  logic signed [ogff_pkg::VALUE_W-1:0]     req_cell_value,
   input  logic [ogff_pkg::COORD_PORT_W-1:0]       req_start_row,
   input  logic [ogff_pkg::COORD_PORT_W-1:0]       req_start_col,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic [ogff_pkg::COORD_PORT_W-1:0]       rsp_found_row,
   output logic [ogff_pkg::COORD_PORT_W-1:0]       rsp_found_col,
   output logic [ogff_pkg::INDEX_W-1:0]            rsp_found_index,
   output logic                                    rsp_found,
   output logic                                    rsp_queue_empty,
   output logic                                    rsp_last,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [ogff_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [ogff_pkg::DIM_REG_W-1:0]          csr_wdata
);
   import ogff_pkg::*;

   localparam int CELLS   = MAX_DIM * MAX_DIM;
   localparam int IDX_W   = $clog2(CELLS);
   localparam int DIM_W   = $clog2(MAX_DIM + 1);
   localparam int COORD_W = $clog2(MAX_DIM);
   localparam int ROW_W   = IDX_W + 1;
   localparam int COL_W   = DIM_W + 1;
   localparam int CMP_W   = (DIM_W > DIM_REG_W) ? DIM_W : DIM_REG_W;
   localparam int SCMP_W  = (DIM_W > COORD_PORT_W) ? DIM_W : COORD_PORT_W;
   localparam int LCMP_W  = (IDX_W + 1 > INDEX_W) ? IDX_W + 1 : INDEX_W;
   localparam int PROD_W  = COORD_PORT_W + DIM_W + 1;
   localparam int ENTRY_W = IDX_W + 2 * COORD_W + DIM_W;

   state_type state_ff, state_in;

   logic [DIM_REG_W-1:0] grid_width_ff, grid_height_ff;
   logic [DIM_W-1:0]     eff_w, eff_h;

   logic                 accept;
   logic                 seed_ok_ff;
   logic [IDX_W-1:0]     seed_idx_ff;
   logic [COORD_W-1:0]   seed_row_ff, seed_col_ff;
   logic [PROD_W-1:0]    seed_prod;
   logic                 seed_ok_in;
   logic [IDX_W-1:0]     clr_addr_ff;

   logic [IDX_W-1:0]     cur_idx_ff;
   logic [IDX_W-1:0]     cur_row_ff;
   logic [DIM_W-1:0]     cur_col_ff;
   logic [1:0]           dir_ff;

   logic [ROW_W-1:0]     row_up, row_dn, h_ext;
   logic [COL_W-1:0]     col_up;
   logic                 cand_ok_in, cand_ok_ff;
   logic [IDX_W-1:0]     cand_idx_in, cand_idx_ff;
   logic [COORD_W-1:0]   cand_row_in, cand_row_ff;
   logic [COORD_W-1:0]   cand_col_in, cand_col_ff;

   logic [HIT_CNT_W-1:0] hit_count_ff;
   logic [IDX_W-1:0]     hit_idx_ff [MAX_HITS];
   logic [COORD_W-1:0]   hit_row_ff [MAX_HITS];
   logic [COORD_W-1:0]   hit_col_ff [MAX_HITS];
   logic [HIT_PTR_W-1:0] drain_ptr_ff;
   logic                 hit;

   logic                 rsp_load;
   logic                 drain_last;
   logic                 drain_found;
   logic [COORD_W-1:0]   drain_row, drain_col;
   logic [IDX_W-1:0]     drain_idx;

   logic                 rsp_valid_ff;
   logic [COORD_PORT_W-1:0] rsp_row_ff, rsp_col_ff;
   logic [INDEX_W-1:0]   rsp_index_ff;
   logic                 rsp_found_ff, rsp_queue_empty_ff, rsp_last_ff;

   cell_ctrl_type        cell_ctrl;
   logic [IDX_W-1:0]     vis_addr;
   logic                 free_bit, visited_bit;

   queue_ctrl_type       queue_ctrl;
   logic [ENTRY_W-1:0]   push_data, pop_data;
   logic                 q_empty;
   logic [IDX_W-1:0]     e_idx;
   logic [COORD_W-1:0]   e_row, e_col;
   logic [DIM_W-1:0]     e_w;
   logic                 width_match;

   logic                 div_start, div_busy;
   logic [IDX_W-1:0]     div_quot;
   logic [DIM_W-1:0]     div_rem;

   always_comb begin
      eff_w = DIM_W'(grid_width_ff);
      if (grid_width_ff == '0) begin
         eff_w = DIM_W'(1);
      end else if (CMP_W'(grid_width_ff) > CMP_W'(MAX_DIM)) begin
         eff_w = DIM_W'(MAX_DIM);
      end
      eff_h = DIM_W'(grid_height_ff);
      if (grid_height_ff == '0) begin
         eff_h = DIM_W'(1);
      end else if (CMP_W'(grid_height_ff) > CMP_W'(MAX_DIM)) begin
         eff_h = DIM_W'(MAX_DIM);
      end
   end

   assign accept     = req_valid && req_ready;
   assign seed_prod  = PROD_W'(req_start_row) * PROD_W'(eff_w) + PROD_W'(req_start_col);
   assign seed_ok_in = (SCMP_W'(req_start_row) < SCMP_W'(eff_h))
                       && (SCMP_W'(req_start_col) < SCMP_W'(eff_w));

   assign {e_idx, e_row, e_col, e_w} = pop_data;
   assign width_match = (e_w == eff_w);

   always_comb begin
      row_up      = ROW_W'(cur_row_ff) + ROW_W'(1);
      row_dn      = ROW_W'(cur_row_ff) - ROW_W'(1);
      col_up      = COL_W'(cur_col_ff) + COL_W'(1);
      h_ext       = ROW_W'(eff_h);
      cand_ok_in  = 1'b0;
      cand_idx_in = cur_idx_ff;
      cand_row_in = COORD_W'(cur_row_ff);
      cand_col_in = COORD_W'(cur_col_ff);
      case (dir_ff)
         DIR_NORTH: begin
            cand_ok_in  = row_up < h_ext;
            cand_idx_in = cur_idx_ff + IDX_W'(eff_w);
            cand_row_in = COORD_W'(row_up);
         end
         DIR_EAST: begin
            cand_ok_in  = (ROW_W'(cur_row_ff) < h_ext) && (col_up < COL_W'(eff_w));
            cand_idx_in = cur_idx_ff + IDX_W'(1);
            cand_col_in = COORD_W'(col_up);
         end
         DIR_SOUTH: begin
            cand_ok_in  = (cur_row_ff != '0) && (row_dn < h_ext);
            cand_idx_in = cur_idx_ff - IDX_W'(eff_w);
            cand_row_in = COORD_W'(row_dn);
         end
         DIR_WEST: begin
            cand_ok_in  = (cur_col_ff != '0) && (ROW_W'(cur_row_ff) < h_ext);
            cand_idx_in = cur_idx_ff - IDX_W'(1);
            cand_col_in = COORD_W'(cur_col_ff - DIM_W'(1));
         end
         default: begin
            cand_ok_in = 1'b0;
         end
      endcase
   end

   always_comb begin
      drain_found = hit_count_ff != '0;
      drain_last  = !drain_found
                    || ((HIT_CNT_W'(drain_ptr_ff) + HIT_CNT_W'(1)) == hit_count_ff);
      drain_row   = drain_found ? hit_row_ff[drain_ptr_ff] : '0;
      drain_col   = drain_found ? hit_col_ff[drain_ptr_ff] : '0;
      drain_idx   = drain_found ? hit_idx_ff[drain_ptr_ff] : '0;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_cmd == CMD_START) begin
               state_in = ST_CLEAR;
            end else if (accept && req_cmd == CMD_STEP) begin
               state_in = ST_POP;
            end
         end
         ST_CLEAR: begin
            if (clr_addr_ff == IDX_W'(CELLS - 1)) begin
               state_in = ST_SEED;
            end
         end
         ST_SEED:   state_in = ST_IDLE;
         ST_POP:    state_in = q_empty ? ST_DRAIN : ST_FETCH;
         ST_FETCH:  state_in = width_match ? ST_ADDR : ST_DIVIDE;
         ST_DIVIDE: begin
            if (!div_busy) begin
               state_in = ST_ADDR;
            end
         end
         ST_ADDR:   state_in = ST_CHECK;
         ST_CHECK:  state_in = (dir_ff == DIR_WEST) ? ST_DRAIN : ST_ADDR;
         ST_DRAIN: begin
            if (rsp_load && drain_last) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready         = (state_ff == ST_IDLE);
      hit               = (state_ff == ST_CHECK) && cand_ok_ff && free_bit && !visited_bit;
      rsp_load          = (state_ff == ST_DRAIN) && (!rsp_valid_ff || rsp_ready);
      div_start         = (state_ff == ST_FETCH) && !width_match;
      cell_ctrl.load_we = accept && (req_cmd == CMD_LOAD)
                          && (LCMP_W'(req_cell_index) < LCMP_W'(CELLS));
      cell_ctrl.read_en = (state_ff == ST_ADDR);
      cell_ctrl.vis_we  = 1'b0;
      cell_ctrl.vis_bit = 1'b1;
      vis_addr          = cand_idx_ff;
      queue_ctrl.flush  = accept && (req_cmd == CMD_START);
      queue_ctrl.push   = 1'b0;
      queue_ctrl.pop    = (state_ff == ST_POP) && !q_empty;
      push_data         = {cand_idx_ff, cand_row_ff, cand_col_ff, eff_w};
      case (state_ff)
         ST_CLEAR: begin
            cell_ctrl.vis_we  = 1'b1;
            cell_ctrl.vis_bit = 1'b0;
            vis_addr          = clr_addr_ff;
         end
         ST_SEED: begin
            cell_ctrl.vis_we = seed_ok_ff;
            vis_addr         = seed_idx_ff;
            queue_ctrl.push  = seed_ok_ff;
            push_data        = {seed_idx_ff, seed_row_ff, seed_col_ff, eff_w};
         end
         ST_CHECK: begin
            cell_ctrl.vis_we = hit;
            queue_ctrl.push  = hit;
         end
         default: begin
            cell_ctrl.vis_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         grid_width_ff  <= DIM_RESET;
         grid_height_ff <= DIM_RESET;
         rsp_valid_ff   <= 1'b0;
         hit_count_ff   <= '0;
         drain_ptr_ff   <= '0;
         dir_ff         <= DIR_NORTH;
         clr_addr_ff    <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_GRID_WIDTH:  grid_width_ff  <= csr_wdata;
               REG_GRID_HEIGHT: grid_height_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (accept) begin
            clr_addr_ff  <= '0;
            hit_count_ff <= '0;
            drain_ptr_ff <= '0;
         end else if (state_ff == ST_CLEAR) begin
            clr_addr_ff <= clr_addr_ff + IDX_W'(1);
         end
         if (hit) begin
            hit_count_ff <= hit_count_ff + HIT_CNT_W'(1);
         end
         if (rsp_load) begin
            drain_ptr_ff <= drain_ptr_ff + HIT_PTR_W'(1);
         end
         if (state_ff == ST_FETCH) begin
            dir_ff <= DIR_NORTH;
         end else if (state_ff == ST_CHECK) begin
            dir_ff <= dir_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_cmd == CMD_START) begin
         seed_ok_ff  <= seed_ok_in;
         seed_idx_ff <= IDX_W'(seed_prod);
         seed_row_ff <= COORD_W'(req_start_row);
         seed_col_ff <= COORD_W'(req_start_col);
      end
      if (state_ff == ST_FETCH) begin
         cur_idx_ff <= e_idx;
         cur_row_ff <= IDX_W'(e_row);
         cur_col_ff <= DIM_W'(e_col);
      end else if (state_ff == ST_DIVIDE && !div_busy) begin
         cur_row_ff <= div_quot;
         cur_col_ff <= div_rem;
      end
      if (state_ff == ST_ADDR) begin
         cand_ok_ff  <= cand_ok_in;
         cand_idx_ff <= cand_idx_in;
         cand_row_ff <= cand_row_in;
         cand_col_ff <= cand_col_in;
      end
      if (hit) begin
         hit_idx_ff[hit_count_ff[HIT_PTR_W-1:0]] <= cand_idx_ff;
         hit_row_ff[hit_count_ff[HIT_PTR_W-1:0]] <= cand_row_ff;
         hit_col_ff[hit_count_ff[HIT_PTR_W-1:0]] <= cand_col_ff;
      end
      if (rsp_load) begin
         rsp_row_ff         <= COORD_PORT_W'(drain_row);
         rsp_col_ff         <= COORD_PORT_W'(drain_col);
         rsp_index_ff       <= INDEX_W'(drain_idx);
         rsp_found_ff       <= drain_found;
         rsp_queue_empty_ff <= q_empty;
         rsp_last_ff        <= drain_last;
      end
   end

   ogff_cell_store #(
      .DEPTH  (CELLS),
      .ADDR_W (IDX_W)
   ) u_cell_store (
      .clock       (clock),
      .ctrl        (cell_ctrl),
      .load_addr   (IDX_W'(req_cell_index)),
      .load_free   (req_cell_value == '0),
      .vis_addr    (vis_addr),
      .rd_addr     (cand_idx_in),
      .free_bit    (free_bit),
      .visited_bit (visited_bit)
   );

   ogff_queue #(
      .DEPTH   (CELLS),
      .ADDR_W  (IDX_W),
      .ENTRY_W (ENTRY_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (queue_ctrl),
      .push_data (push_data),
      .pop_data  (pop_data),
      .empty     (q_empty)
   );

   ogff_divider #(
      .DIVIDEND_W (IDX_W),
      .DIVISOR_W  (DIM_W)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (e_idx),
      .divisor   (eff_w),
      .busy      (div_busy),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found_row   = rsp_row_ff;
   assign rsp_found_col   = rsp_col_ff;
   assign rsp_found_index = rsp_index_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_queue_empty = rsp_queue_empty_ff;
   assign rsp_last        = rsp_last_ff;

   a_found_not_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_found_ff |-> !rsp_queue_empty_ff)
      else $error("found word reports an empty queue");

   a_hit_queues: assert property (@(posedge clock) disable iff (reset)
      hit |=> !q_empty)
      else $error("newly reached cell did not enter the queue");

   a_div_idle_start: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("divider started while busy");

   a_cand_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK) && cand_ok_ff |-> (ROW_W'(cand_idx_ff) < ROW_W'(CELLS)))
      else $error("neighbour index beyond the grid store");

endmodule
